// ----- rtl/core/text_line_ending_filter_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the text line ending filter
// Clocked on clk, disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef TEXT_LINE_ENDING_FILTER_DEFINES_SVH
`define TEXT_LINE_ENDING_FILTER_DEFINES_SVH

// Same-cycle implication
`define TLEF_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define TLEF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/tlef_pkg.sv -----
// ----------------------------------------------------------------------------
// tlef_pkg
// Types and constants shared by the text line ending filter.
// ----------------------------------------------------------------------------
package tlef_pkg;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_EXCL  = 8'h21;
  localparam logic [7:0] CH_TILDE = 8'h7E;
  localparam logic [7:0] CH_EOT   = 8'h1A;

  localparam logic [1:0] SP_ASIS   = 2'd0;
  localparam logic [1:0] SP_DOUBLE = 2'd1;
  localparam logic [1:0] SP_SINGLE = 2'd2;

  localparam logic [2:0] CFG_KEEP_BLANKS      = 3'd0;
  localparam logic [2:0] CFG_ADD_CR_BEFORE_LF = 3'd1;
  localparam logic [2:0] CFG_KEEP_LF          = 3'd2;
  localparam logic [2:0] CFG_ADD_LF_AFTER_CR  = 3'd3;
  localparam logic [2:0] CFG_KEEP_CR          = 3'd4;
  localparam logic [2:0] CFG_SPACING_MODE     = 3'd5;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_DBL_CR,
    PH_SGL_CR,
    PH_SGL_CRLF,
    PH_SGL_HELD
  } phase_t;

  typedef struct packed {
    logic       keep_blanks;
    logic       add_cr_before_lf;
    logic       keep_lf;
    logic       add_lf_after_cr;
    logic       keep_cr;
    logic [1:0] spacing_mode;
  } cfg_t;

  // bytes: first byte in the lowest bits; cnt: 1..3; eot marks the last byte
  typedef struct packed {
    logic [23:0] bytes;
    logic [1:0]  cnt;
    logic        eot;
  } job_t;

endpackage

// ----- rtl/core/tlef_front.sv -----
// ----------------------------------------------------------------------------
// tlef_front
// Classifies each input byte, tracks the lookahead phase and builds a job
// of up to three output bytes.
// ----------------------------------------------------------------------------
module tlef_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      data_byte,
  input  logic            end_marker,
  input  tlef_pkg::cfg_t  cfg,
  output logic            push_valid,
  input  logic            push_ready,
  output tlef_pkg::job_t  job
);
  import tlef_pkg::*;

  phase_t phase;
  phase_t phase_next;

  logic        accept;
  logic        end_item;
  logic        is_lf;
  logic        is_cr;
  logic        match;
  logic [23:0] ob;
  logic [1:0]  n;
  logic        eot;

  function automatic logic [23:0] place(logic [7:0] x, logic [1:0] pos);
    return {16'h0000, x} << {pos, 3'b000};
  endfunction

  assign in_ready = push_ready;
  assign accept   = in_valid && in_ready;
  assign end_item = end_marker || (data_byte == CH_EOT);
  assign is_lf    = !end_item && (data_byte == CH_LF);
  assign is_cr    = !end_item && (data_byte == CH_CR);

  assign match = ((phase == PH_DBL_CR)   && is_lf) ||
                 ((phase == PH_SGL_CR)   && is_lf) ||
                 ((phase == PH_SGL_CRLF) && is_cr) ||
                 ((phase == PH_SGL_HELD) && is_lf);

  always_comb begin
    phase_next = PH_IDLE;
    if (match) begin
      case (phase)
        PH_SGL_CR:   phase_next = PH_SGL_CRLF;
        PH_SGL_CRLF: phase_next = PH_SGL_HELD;
        default:     phase_next = PH_IDLE;
      endcase
    end else if (is_cr) begin
      case (cfg.spacing_mode)
        SP_DOUBLE: phase_next = PH_DBL_CR;
        SP_SINGLE: phase_next = PH_SGL_CR;
        default:   phase_next = PH_IDLE;
      endcase
    end
  end

  always_comb begin
    ob  = '0;
    n   = '0;
    eot = 1'b0;
    if (match) begin
      case (phase)
        PH_DBL_CR: begin
          ob = {CH_LF, CH_CR, CH_LF};
          n  = 2'd3;
        end
        PH_SGL_CR: begin
          ob = place(CH_LF, 2'd0);
          n  = 2'd1;
        end
        default: ;
      endcase
    end else begin
      if (phase == PH_SGL_HELD) begin
        ob = place(CH_CR, 2'd0);
        n  = 2'd1;
      end
      if (end_item) begin
        ob  = ob | place(CH_EOT, n);
        n   = n + 2'd1;
        eot = 1'b1;
      end else if (data_byte inside {CH_TAB, [CH_EXCL:CH_TILDE]}) begin
        ob = ob | place(data_byte, n);
        n  = n + 2'd1;
      end else if (data_byte == CH_SPACE) begin
        if (cfg.keep_blanks) begin
          ob = ob | place(data_byte, n);
          n  = n + 2'd1;
        end
      end else if (data_byte == CH_LF) begin
        if (cfg.add_cr_before_lf) begin
          ob = ob | place(CH_CR, n);
          n  = n + 2'd1;
        end
        if (cfg.keep_lf) begin
          ob = ob | place(CH_LF, n);
          n  = n + 2'd1;
        end
      end else if (data_byte == CH_CR) begin
        if (cfg.spacing_mode == SP_DOUBLE || cfg.spacing_mode == SP_SINGLE) begin
          ob = ob | place(CH_CR, n);
          n  = n + 2'd1;
        end else begin
          if (cfg.keep_cr) begin
            ob = ob | place(CH_CR, n);
            n  = n + 2'd1;
          end
          if (cfg.add_lf_after_cr) begin
            ob = ob | place(CH_LF, n);
            n  = n + 2'd1;
          end
        end
      end
    end
  end

  assign push_valid = accept && (n != 2'd0);
  assign job.bytes  = ob;
  assign job.cnt    = n;
  assign job.eot    = eot;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
    end else if (accept) begin
      phase <= phase_next;
    end
  end

endmodule

// ----- rtl/core/tlef_fifo.sv -----
// ----------------------------------------------------------------------------
// tlef_fifo
// Short job queue between the front and back parts.
// ----------------------------------------------------------------------------
module tlef_fifo #(
  parameter int DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  tlef_pkg::job_t  in_job,
  output logic            out_valid,
  input  logic            out_ready,
  output tlef_pkg::job_t  out_job
);
  import tlef_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  job_t          mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          push;
  logic          pop;

  assign in_ready  = (count != CW'(DEPTH));
  assign out_valid = (count != '0);
  assign push      = in_valid && in_ready;
  assign pop       = out_ready && out_valid;
  assign out_job   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/core/tlef_back.sv -----
// ----------------------------------------------------------------------------
// tlef_back
// Unpacks queued jobs and sends one output word per cycle while m_tready is high.
// ----------------------------------------------------------------------------
module tlef_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  output logic            q_ready,
  input  tlef_pkg::job_t  q_job,
  output logic            m_tvalid,
  input  logic            m_tready,
  output logic [7:0]      m_tdata,
  output logic            m_tlast,
  output logic            m_tuser
);
  import tlef_pkg::*;
  `include "text_line_ending_filter_defines.svh"

  job_t       cur;
  logic [1:0] idx;
  logic       busy;
  logic       take;

  assign m_tvalid = busy;
  assign m_tdata  = cur.bytes[{idx, 3'b000} +: 8];
  assign m_tlast  = (idx == cur.cnt - 2'd1);
  assign m_tuser  = cur.eot && m_tlast;
  assign take     = m_tvalid && m_tready;
  assign q_ready  = !busy || (take && m_tlast);

  always_ff @(posedge clk) begin
    if (q_valid && q_ready) begin
      cur <= q_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (q_valid && q_ready) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (take && m_tlast) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (take) begin
      idx <= idx + 2'd1;
    end
  end

  `TLEF_ASSERT_IMPLY(a_cnt_nonzero, busy, cur.cnt != 2'd0, "empty job loaded")
  `TLEF_ASSERT_IMPLY(a_idx_in_range, busy, idx < cur.cnt, "byte index past job end")
  `TLEF_ASSERT_IMPLY(a_eot_byte, m_tvalid && m_tuser, m_tdata == CH_EOT, "end mark on non-EOT byte")
  `TLEF_ASSERT_NEXT(a_drain_idle, take && m_tlast && !q_valid, !m_tvalid, "valid after drain")

endmodule

// ----- rtl/core/text_line_ending_filter.sv -----
// ----------------------------------------------------------------------------
// text_line_ending_filter: each accepted byte's job is written to the queue
// and then loaded into the back part's register before its first word is offered.
// Input takes one byte per cycle while the queue has room. Output sends one
// word per cycle while m_tready is high; a byte makes 0 to 3 words.
// Synchronous reset clears config to defaults, phase to idle, queue empty.
// ----------------------------------------------------------------------------
module text_line_ending_filter #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] data_byte
  input  logic       s_tlast,   // end_marker
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_byte
  output logic       m_tlast,   // last_in_run
  output logic       m_tuser,   // end_of_text
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [1:0] cfg_data
);
  import tlef_pkg::*;

  cfg_t cfg;
  job_t push_job;
  job_t pop_job;
  logic push_valid;
  logic push_ready;
  logic pop_valid;
  logic pop_ready;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.keep_blanks      <= 1'b1;
      cfg.add_cr_before_lf <= 1'b0;
      cfg.keep_lf          <= 1'b1;
      cfg.add_lf_after_cr  <= 1'b0;
      cfg.keep_cr          <= 1'b1;
      cfg.spacing_mode     <= SP_ASIS;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_KEEP_BLANKS:      cfg.keep_blanks      <= cfg_data[0];
        CFG_ADD_CR_BEFORE_LF: cfg.add_cr_before_lf <= cfg_data[0];
        CFG_KEEP_LF:          cfg.keep_lf          <= cfg_data[0];
        CFG_ADD_LF_AFTER_CR:  cfg.add_lf_after_cr  <= cfg_data[0];
        CFG_KEEP_CR:          cfg.keep_cr          <= cfg_data[0];
        CFG_SPACING_MODE:     cfg.spacing_mode     <= cfg_data;
        default: ;
      endcase
    end
  end

  tlef_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .data_byte  (s_tdata),
    .end_marker (s_tlast),
    .cfg        (cfg),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .job        (push_job)
  );

  tlef_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (push_valid),
    .in_ready  (push_ready),
    .in_job    (push_job),
    .out_valid (pop_valid),
    .out_ready (pop_ready),
    .out_job   (pop_job)
  );

  tlef_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (pop_valid),
    .q_ready  (pop_ready),
    .q_job    (pop_job),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule

// ----- bench/tb.sv -----
// ----------------------------------------------------------------------------
// tb: line ending filter testbench
// Feeds directed and random byte streams through several register settings.
// Expected output words are predicted per accepted byte and checked in order.
// Both stream sides throttle at random, and one long output stall backs up
// the input.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tlef_pkg::*;

  localparam int CYCLE_LIMIT     = 400000;
  localparam int SETTLE_CYCLES   = 10;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int PHASE_COUNT     = 12;
  localparam int PHASE_ITEMS     = 27;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_in_run;
    logic       end_of_text;
  } word_t;

  class line_filter_scoreboard;
    cfg_t   regs;
    phase_t phase;
    word_t  expected_words[$];
    word_t  run_words[$];
    int     errors;

    function new();
      regs.keep_blanks      = 1'b1;
      regs.add_cr_before_lf = 1'b0;
      regs.keep_lf          = 1'b1;
      regs.add_lf_after_cr  = 1'b0;
      regs.keep_cr          = 1'b1;
      regs.spacing_mode     = SP_ASIS;
      phase  = PH_IDLE;
      errors = 0;
    endfunction

    function void set_reg(logic [2:0] index, logic [1:0] data);
      case (index)
        CFG_KEEP_BLANKS:      regs.keep_blanks      = data[0];
        CFG_ADD_CR_BEFORE_LF: regs.add_cr_before_lf = data[0];
        CFG_KEEP_LF:          regs.keep_lf          = data[0];
        CFG_ADD_LF_AFTER_CR:  regs.add_lf_after_cr  = data[0];
        CFG_KEEP_CR:          regs.keep_cr          = data[0];
        CFG_SPACING_MODE:     regs.spacing_mode     = data;
        default: ;
      endcase
    endfunction

    function void add_byte(logic [7:0] b, logic eot);
      word_t w;
      w.out_byte    = b;
      w.last_in_run = 1'b0;
      w.end_of_text = eot;
      run_words.push_back(w);
    endfunction

    function void filter_plain(logic [7:0] b);
      if (b == CH_TAB || (b > CH_SPACE && b <= CH_TILDE)) begin
        add_byte(b, 1'b0);
      end else if (b == CH_SPACE) begin
        if (regs.keep_blanks) add_byte(b, 1'b0);
      end else if (b == CH_LF) begin
        if (regs.add_cr_before_lf) add_byte(CH_CR, 1'b0);
        if (regs.keep_lf) add_byte(CH_LF, 1'b0);
      end else if (b == CH_CR) begin
        if (regs.spacing_mode == SP_DOUBLE) begin
          add_byte(CH_CR, 1'b0);
          phase = PH_DBL_CR;
        end else if (regs.spacing_mode == SP_SINGLE) begin
          add_byte(CH_CR, 1'b0);
          phase = PH_SGL_CR;
        end else begin
          if (regs.keep_cr) add_byte(CH_CR, 1'b0);
          if (regs.add_lf_after_cr) add_byte(CH_LF, 1'b0);
        end
      end
    endfunction

    function void note_input(logic [7:0] b, logic mark);
      logic   ends;
      logic   done;
      phase_t prior;
      word_t  w;
      ends  = mark || (b == CH_EOT);
      prior = phase;
      phase = PH_IDLE;
      done  = 1'b0;
      run_words.delete();
      case (prior)
        PH_DBL_CR: begin
          if (!ends && b == CH_LF) begin
            add_byte(CH_LF, 1'b0);
            add_byte(CH_CR, 1'b0);
            add_byte(CH_LF, 1'b0);
            done = 1'b1;
          end
        end
        PH_SGL_CR: begin
          if (!ends && b == CH_LF) begin
            add_byte(CH_LF, 1'b0);
            phase = PH_SGL_CRLF;
            done  = 1'b1;
          end
        end
        PH_SGL_CRLF: begin
          if (!ends && b == CH_CR) begin
            phase = PH_SGL_HELD;
            done  = 1'b1;
          end
        end
        PH_SGL_HELD: begin
          if (!ends && b == CH_LF) done = 1'b1;
          else add_byte(CH_CR, 1'b0);
        end
        default: ;
      endcase
      if (!done) begin
        if (ends) begin
          add_byte(CH_EOT, 1'b1);
          phase = PH_IDLE;
        end else begin
          filter_plain(b);
        end
      end
      for (int i = 0; i < run_words.size(); i++) begin
        w = run_words[i];
        w.last_in_run = (i == run_words.size() - 1);
        expected_words.push_back(w);
      end
    endfunction

    function void check_word(logic [7:0] b, logic last, logic eot);
      word_t want;
      if (expected_words.size() == 0) begin
        $error("unexpected word: out_byte %h last_in_run %b end_of_text %b", b, last, eot);
        errors++;
        return;
      end
      want = expected_words.pop_front();
      if (b !== want.out_byte) begin
        $error("out_byte: expected %h, got %h", want.out_byte, b);
        errors++;
      end
      if (last !== want.last_in_run) begin
        $error("last_in_run: expected %b, got %b", want.last_in_run, last);
        errors++;
      end
      if (eot !== want.end_of_text) begin
        $error("end_of_text: expected %b, got %b", want.end_of_text, eot);
        errors++;
      end
    endfunction
  endclass

  logic       clk;
  logic       rst;
  logic       s_tvalid;
  logic       s_tready;
  logic [7:0] s_tdata;
  logic       s_tlast;
  logic       m_tvalid;
  logic       m_tready;
  logic [7:0] m_tdata;
  logic       m_tlast;
  logic       m_tuser;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [2:0] cfg_index;
  logic [1:0] cfg_data;

  line_filter_scoreboard sb;
  bit quiet;
  bit choke_req;
  int items_sent;
  int cycle_count;

  text_line_ending_filter u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** text_line_ending_filter: FAILED **");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 2);
    if (r < 97) return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  // output side: throttle ready, check every accepted word
  initial begin
    int stall_left;
    stall_left = 0;
    m_tready   = 1'b0;
    forever begin
      @(negedge clk);
      if (choke_req) begin
        stall_left = HOLD_OFF_CYCLES;
        choke_req  = 1'b0;
      end
      if (stall_left > 0) begin
        m_tready = 1'b0;
        stall_left--;
      end else begin
        m_tready   = 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_word(m_tdata, m_tlast, m_tuser);
  end

  task automatic send_word(input logic [7:0] b, input logic mark);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid = 1'b0;
      s_tdata  = 8'($urandom);
      s_tlast  = 1'($urandom);
      repeat (gap) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = b;
    s_tlast  = mark;
    do @(posedge clk); while (!s_tready);
    sb.note_input(b, mark);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] index, input logic [1:0] data);
    cfg_valid = 1'b1;
    cfg_index = index;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(index, data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic wait_drained();
    s_tvalid = 1'b0;
    while (sb.expected_words.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic send_token();
    int r;
    logic [7:0] c;
    r = $urandom_range(0, 99);
    if (r < 35) begin
      if ($urandom_range(0, 9) == 0) c = $urandom_range(0, 1) ? CH_SPACE : CH_TAB;
      else c = 8'($urandom_range(CH_EXCL, CH_TILDE));
      send_word(c, 1'b0);
    end else if (r < 55) begin
      send_word(CH_CR, 1'b0);
      send_word(CH_LF, 1'b0);
    end else if (r < 68) begin
      send_word(CH_CR, 1'b0);
      send_word(CH_LF, 1'b0);
      send_word(CH_CR, 1'b0);
      send_word(CH_LF, 1'b0);
    end else if (r < 76) begin
      send_word(CH_LF, 1'b0);
    end else if (r < 84) begin
      send_word(CH_CR, 1'b0);
    end else if (r < 94) begin
      send_word(8'($urandom), 1'b0);
    end else if (r < 97) begin
      send_word(CH_EOT, 1'b0);
    end else begin
      send_word(8'($urandom), 1'b1);
    end
  endtask

  initial begin
    int start;
    logic [1:0] value;
    sb          = new();
    rst         = 1'b1;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    s_tlast     = 1'b0;
    cfg_valid   = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    quiet       = 1'b0;
    choke_req   = 1'b0;
    items_sent  = 0;
    cycle_count = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset settings: byte classes, lone line endings, end marker
    send_word(8'h00, 1'b0);
    send_word(8'hFF, 1'b0);
    send_word(CH_TAB, 1'b0);
    send_word(CH_SPACE, 1'b0);
    send_word(CH_EXCL, 1'b0);
    send_word(CH_TILDE, 1'b0);
    send_word(8'h7F, 1'b0);
    send_word(CH_LF, 1'b0);
    send_word(CH_CR, 1'b0);
    send_word(8'h41, 1'b1);
    wait_drained();

    // strip blanks, rewrite LF and CR
    write_reg(CFG_KEEP_BLANKS, 2'd0);
    write_reg(CFG_ADD_CR_BEFORE_LF, 2'd1);
    write_reg(CFG_KEEP_LF, 2'd0);
    write_reg(CFG_ADD_LF_AFTER_CR, 2'd1);
    write_reg(CFG_KEEP_CR, 2'd0);
    send_word(CH_SPACE, 1'b0);
    send_word(CH_LF, 1'b0);
    send_word(CH_CR, 1'b0);
    wait_drained();

    // double spacing: expand pair, then end right after CR
    write_reg(CFG_SPACING_MODE, SP_DOUBLE);
    send_word(CH_CR, 1'b0);
    send_word(CH_LF, 1'b0);
    send_word(CH_CR, 1'b0);
    send_word(8'h00, 1'b1);
    wait_drained();

    // single spacing: drop repeat, release held CR on mismatch and on end
    write_reg(CFG_SPACING_MODE, SP_SINGLE);
    send_word(CH_CR, 1'b0);
    send_word(CH_LF, 1'b0);
    send_word(CH_CR, 1'b0);
    send_word(CH_LF, 1'b0);
    send_word(CH_CR, 1'b0);
    send_word(CH_LF, 1'b0);
    send_word(CH_CR, 1'b0);
    send_word(8'h61, 1'b0);
    send_word(CH_CR, 1'b0);
    send_word(CH_LF, 1'b0);
    send_word(CH_CR, 1'b0);
    send_word(CH_EOT, 1'b0);
    wait_drained();

    // unused spacing code behaves as is
    write_reg(CFG_SPACING_MODE, 2'd3);
    send_word(CH_CR, 1'b0);
    send_word(CH_LF, 1'b0);
    wait_drained();

    for (int k = 0; k < PHASE_COUNT; k++) begin
      for (int idx = CFG_KEEP_BLANKS; idx <= CFG_SPACING_MODE; idx++) begin
        if (k == 0) value = 2'd0;
        else if (k == 1) value = (idx == CFG_SPACING_MODE) ? SP_SINGLE : 2'd3;
        else value = 2'($urandom_range(0, 3));
        write_reg(3'(idx), value);
      end
      if (k == 2) write_reg(CFG_SPACING_MODE + 3'($urandom_range(1, 2)), 2'($urandom));
      quiet = ($urandom_range(0, 3) == 0);
      if (k == 4) begin
        quiet     = 1'b1;
        choke_req = 1'b1;
      end
      start = items_sent;
      while (items_sent - start < PHASE_ITEMS) send_token();
      wait_drained();
    end

    if (sb.errors == 0) begin
      $display("** text_line_ending_filter: PASSED **");
    end else begin
      $display("** text_line_ending_filter: FAILED **");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/tlef_pkg.sv
rtl/core/tlef_front.sv
rtl/core/tlef_fifo.sv
rtl/core/tlef_back.sv
rtl/core/text_line_ending_filter.sv
bench/tb.sv
